FILE: rtl/b2r_pkg.sv
// Shared types, letter codes and digit pattern helpers for the Roman numeral converter.
`timescale 1ns / 1ps
`default_nettype none
package b2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned BCD_W    = 16;
    localparam int unsigned STEP_W   = 2;
    localparam int unsigned CNT_W    = 4;

    localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

    localparam logic [LETTER_W-1:0] ASCII_NUL = 7'h00;
    localparam logic [LETTER_W-1:0] ASCII_I   = 7'h49;
    localparam logic [LETTER_W-1:0] ASCII_V   = 7'h56;
    localparam logic [LETTER_W-1:0] ASCII_X   = 7'h58;
    localparam logic [LETTER_W-1:0] ASCII_L   = 7'h4C;
    localparam logic [LETTER_W-1:0] ASCII_C   = 7'h43;
    localparam logic [LETTER_W-1:0] ASCII_D   = 7'h44;
    localparam logic [LETTER_W-1:0] ASCII_M   = 7'h4D;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [3:0]          t_digit;

    // Indexed by decimal position: units, tens, hundreds, thousands
    localparam t_letter ONE_LETTER  [4] = '{ASCII_I, ASCII_X, ASCII_C, ASCII_M};
    localparam t_letter FIVE_LETTER [4] = '{ASCII_V, ASCII_L, ASCII_D, ASCII_NUL};
    localparam t_letter TEN_LETTER  [4] = '{ASCII_X, ASCII_C, ASCII_M, ASCII_NUL};

    // Double-dabble correction for one BCD nibble
    function automatic t_digit bcd_adjust(input t_digit d);
        bcd_adjust = (d >= 4'd5) ? t_digit'(d + 4'd3) : d;
    endfunction

    // Number of letters a decimal digit produces
    function automatic logic [2:0] digit_len(input t_digit d);
        case (d)
            4'd0:    digit_len = 3'd0;
            4'd1:    digit_len = 3'd1;
            4'd2:    digit_len = 3'd2;
            4'd3:    digit_len = 3'd3;
            4'd4:    digit_len = 3'd2;
            4'd5:    digit_len = 3'd1;
            4'd6:    digit_len = 3'd2;
            4'd7:    digit_len = 3'd3;
            4'd8:    digit_len = 3'd4;
            4'd9:    digit_len = 3'd2;
            default: digit_len = 3'd0;
        endcase
    endfunction

    // Letter at a given step within a digit's pattern
    function automatic t_letter digit_letter(input t_digit d, input logic [STEP_W-1:0] step,
                                             input logic [1:0] pos);
        t_letter one_l;
        t_letter five_l;
        t_letter ten_l;
        one_l  = ONE_LETTER[pos];
        five_l = FIVE_LETTER[pos];
        ten_l  = TEN_LETTER[pos];
        case (d)
            4'd9:    digit_letter = (step == '0) ? one_l : ten_l;
            4'd4:    digit_letter = (step == '0) ? one_l : five_l;
            default: digit_letter = ((d >= 4'd5) && (step == '0)) ? five_l : one_l;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/binary_to_roman_numeral.sv
// Top level: binary to Roman numeral converter, one ASCII letter per result.
// After accept, a 12-step bit-serial binary-to-BCD shift loop runs, then one emit step per
// letter or skipped zero digit, starting from the thousands digit; letters are registered.
// A valid item is busy through its shift and up to 15 emit steps, taking no new item; an
// invalid item shows its single result next cycle and never goes busy.
// Reset (sync, active low) returns to idle and drops any strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module binary_to_roman_numeral (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [b2r_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic [b2r_pkg::LETTER_W-1:0]       o_letter,
    output logic                               o_last,
    output logic                               o_invalid
);
    import b2r_pkg::*;

    // IDLE: waiting for an item. CONV: double dabble, one input bit per cycle.
    // EMIT: walk digits from thousands down, one letter per cycle.
    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} t_state_e;

    t_state_e             r_state,   n_state;
    logic [VALUE_W-1:0]   r_bin,     n_bin;     // binary bits still to shift in
    logic [BCD_W-1:0]     r_bcd,     n_bcd;     // current digit in the top nibble during emit
    logic [CNT_W-1:0]     r_cnt,     n_cnt;
    logic [1:0]           r_pos,     n_pos;     // decimal position of the top nibble
    logic [STEP_W-1:0]    r_step,    n_step;    // letter index within the digit
    logic                 r_valid,   n_valid;
    t_letter              r_letter,  n_letter;
    logic                 r_last,    n_last;
    logic                 r_invalid, n_invalid;

    logic [BCD_W-1:0]     w_bcd_adj;
    t_digit               w_dig;
    logic [2:0]           w_len;
    logic                 w_dig_end;
    logic                 w_rest_zero;
    logic                 w_bad;

    // Add-3 correction on every nibble before each shift
    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            w_bcd_adj[i*4 +: 4] = bcd_adjust(r_bcd[i*4 +: 4]);
        end
    end

    assign w_dig       = r_bcd[BCD_W-1 -: 4];
    assign w_len       = digit_len(w_dig);
    assign w_dig_end   = ({1'b0, r_step} == (w_len - 3'd1));
    assign w_rest_zero = (r_bcd[BCD_W-5:0] == '0);
    assign w_bad       = (i_value == '0) || (i_value > MAX_VALID);

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_step    = r_step;
        n_valid   = 1'b0;
        n_letter  = r_letter;
        n_last    = r_last;
        n_invalid = r_invalid;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (w_bad) begin
                        // Out of range: one flagged result straight away
                        n_valid   = 1'b1;
                        n_letter  = ASCII_NUL;
                        n_last    = 1'b1;
                        n_invalid = 1'b1;
                    end else begin
                        n_bin   = i_value;
                        n_bcd   = '0;
                        n_cnt   = CNT_W'(VALUE_W - 1);
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = {w_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_pos   = 2'd3;
                    n_step  = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_len == 3'd0) begin
                    // zero digit: nothing to write, move on
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_pos  = r_pos - 1'b1;
                    n_step = '0;
                end else begin
                    n_valid   = 1'b1;
                    n_letter  = digit_letter(w_dig, r_step, r_pos);
                    n_invalid = 1'b0;
                    n_last    = w_dig_end && w_rest_zero;
                    if (w_dig_end) begin
                        n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                        n_pos  = r_pos - 1'b1;
                        n_step = '0;
                        if (w_rest_zero) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_step    <= n_step;
        r_letter  <= n_letter;
        r_last    <= n_last;
        r_invalid <= n_invalid;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_letter  = r_letter;
    assign o_last    = r_last;
    assign o_invalid = r_invalid;

endmodule
`default_nettype wire

FILE: dv/binary_to_roman_numeral_tb.sv
// Self-checking testbench for the binary to Roman numeral converter: directed table, then random items.
`timescale 1ns / 1ps
module binary_to_roman_numeral_tb;
    import b2r_pkg::*;

    // Run length and guard
    localparam int unsigned RANDOM_ITEMS = 287;
    localparam int unsigned DRAIN_CYCLES = 40;       // longest numeral plus digit split, with margin
    localparam int unsigned CYCLE_LIMIT  = 200000;   // upper bound on the whole run
    localparam int unsigned REPORT_MAX   = 10;

    // How a directed row gets its expected letters
    typedef enum logic [1:0] {
        ROW_MODEL,     // worked out by the predictor
        ROW_TEXT,      // numeral typed in the table
        ROW_INVALID    // single flagged result, from spell_invalid
    } t_row_kind;

    // One result as the block shows it
    typedef struct packed {
        t_letter letter;
        logic    last;
        logic    invalid;
    } t_numeral_letter;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [LETTER_W-1:0]  o_letter;
    logic                 o_last;
    logic                 o_invalid;

    binary_to_roman_numeral DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_value   (i_value),
        .o_busy    (o_busy),
        .o_valid   (o_valid),
        .o_letter  (o_letter),
        .o_last    (o_last),
        .o_invalid (o_invalid)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Letters of the numeral being worked out
    t_numeral_letter spelled[$];
    // Letters of items driven but not yet taken, and how many belong to each item
    t_numeral_letter letters_offered[$];
    int unsigned     count_offered[$];
    // Letters of accepted items still to come out, oldest first
    t_numeral_letter letters_due[$];

    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    int unsigned calm_left   = 0;
    int unsigned moved;
    t_numeral_letter due;

    // Directed table
    logic [VALUE_W-1:0] row_value[$];
    t_row_kind          row_kind[$];
    string              row_text[$];

    function automatic void add_letter(input t_letter l);
        t_numeral_letter r;
        r.letter  = l;
        r.last    = 1'b0;
        r.invalid = 1'b0;
        spelled.push_back(r);
    endfunction

    function automatic void mark_last();
        t_numeral_letter r;
        r = spelled.pop_back();
        r.last = 1'b1;
        spelled.push_back(r);
    endfunction

    function automatic void spell_invalid();
        t_numeral_letter r;
        r.letter  = ASCII_NUL;
        r.last    = 1'b1;
        r.invalid = 1'b1;
        spelled.delete();
        spelled.push_back(r);
    endfunction

    // One decimal digit: units, five-letter plus units, or subtractive 4 and 9
    function automatic void spell_digit(input int unsigned d, input t_letter one_l,
                                        input t_letter five_l, input t_letter ten_l);
        int unsigned units;
        units = d;
        if (d == 9) begin
            add_letter(one_l);
            add_letter(ten_l);
        end else if (d == 4) begin
            add_letter(one_l);
            add_letter(five_l);
        end else begin
            if (d >= 5) begin
                add_letter(five_l);
                units = d - 5;
            end
            repeat (units) add_letter(one_l);
        end
    endfunction

    // Predictor: expected letters for one value
    function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
        int unsigned n;
        n = v;
        if (n == 0 || v > MAX_VALID) begin
            spell_invalid();
            return;
        end
        spelled.delete();
        repeat (n / 1000) add_letter(ASCII_M);
        spell_digit((n / 100) % 10, ASCII_C, ASCII_D, ASCII_M);
        spell_digit((n / 10) % 10, ASCII_X, ASCII_L, ASCII_C);
        spell_digit(n % 10, ASCII_I, ASCII_V, ASCII_X);
        mark_last();
    endfunction

    // Numeral typed in the table, as ASCII
    function automatic void spell_text(input string s);
        spelled.delete();
        for (int i = 0; i < s.len(); i++)
            add_letter(t_letter'(s[i]));
        mark_last();
    endfunction

    // Sender gap: drawn at random before each item, with runs of back-to-back items now and then
    function automatic int unsigned draw_gap();
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
            calm_left = $urandom_range(4, 20);
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return '0;
        else if (pick < 9)
            return VALUE_W'($urandom_range(4000, 4095));
        else if (pick < 18)
            return VALUE_W'($urandom_range(1, 49));
        else
            return VALUE_W'($urandom_range(1, 3999));
    endfunction

    task automatic add_row(input logic [VALUE_W-1:0] v, input t_row_kind k, input string s);
        row_value.push_back(v);
        row_kind.push_back(k);
        row_text.push_back(s);
    endtask

    // Offers one item; returns at the edge that takes it. Start stays high when the
    // next item follows with no gap, so it is never lowered and raised in one step.
    task automatic send_item(input logic [VALUE_W-1:0] v, input int unsigned gap);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        foreach (spelled[i])
            letters_offered.push_back(spelled[i]);
        count_offered.push_back(spelled.size());
        i_start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Monitor: checks each strobed letter against the oldest expectation, then
    // moves the letters of a newly taken item onto the due list. Results at this
    // edge always belong to earlier items, so the order of the two is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (letters_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("%0t: letter with none due: letter %h last %b invalid %b",
                                 $realtime, o_letter, o_last, o_invalid);
                end else begin
                    due = letters_due.pop_front();
                    if (o_letter !== due.letter || o_last !== due.last ||
                        o_invalid !== due.invalid) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, due.letter, due.last, due.invalid,
                                     o_letter, o_last, o_invalid);
                    end
                end
            end
            if (i_start && !o_busy) begin
                moved = count_offered.pop_front();
                repeat (moved) letters_due.push_back(letters_offered.pop_front());
            end
        end
    end

    // Guard against a hung block
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_to_roman_numeral_tb NOT OK");
            $finish;
        end
    end

    initial begin
        // Zero, out-of-range and all-ones values: one flagged result
        add_row(12'd0,    ROW_INVALID, "");
        add_row(12'd4000, ROW_INVALID, "");
        add_row(12'd4095, ROW_INVALID, "");
        // Smallest, largest and longest numerals
        add_row(12'd1,    ROW_TEXT,    "I");
        add_row(12'd3999, ROW_TEXT,    "MMMCMXCIX");
        add_row(12'd3888, ROW_TEXT,    "MMMDCCCLXXXVIII");
        add_row(12'd1000, ROW_TEXT,    "M");
        add_row(12'd3000, ROW_TEXT,    "MMM");
        // Subtractive forms and five-letters in every position
        add_row(12'd4,    ROW_MODEL,   "");
        add_row(12'd9,    ROW_MODEL,   "");
        add_row(12'd5,    ROW_MODEL,   "");
        add_row(12'd8,    ROW_MODEL,   "");
        add_row(12'd40,   ROW_MODEL,   "");
        add_row(12'd90,   ROW_MODEL,   "");
        add_row(12'd50,   ROW_MODEL,   "");
        add_row(12'd400,  ROW_MODEL,   "");
        add_row(12'd900,  ROW_MODEL,   "");
        add_row(12'd500,  ROW_MODEL,   "");
        add_row(12'd10,   ROW_MODEL,   "");
        add_row(12'd100,  ROW_MODEL,   "");
        add_row(12'd444,  ROW_MODEL,   "");
        add_row(12'd999,  ROW_MODEL,   "");
        add_row(12'd1994, ROW_MODEL,   "");
        add_row(12'd2048, ROW_MODEL,   "");

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (row_value[r]) begin
            case (row_kind[r])
                ROW_MODEL: spell_numeral(row_value[r]);
                ROW_TEXT:  spell_text(row_text[r]);
                default:   spell_invalid();
            endcase
            send_item(row_value[r], draw_gap());
        end

        repeat (RANDOM_ITEMS) begin
            begin
                logic [VALUE_W-1:0] v;
                v = draw_value();
                spell_numeral(v);
                send_item(v, draw_gap());
            end
        end
        i_start <= 1'b0;

        // Wait for every due letter, then a quiet spell for strays
        while (letters_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && letters_due.size() == 0)
            $display("binary_to_roman_numeral_tb OK");
        else
            $display("binary_to_roman_numeral_tb NOT OK");
        $finish;
    end

endmodule

FILE: binary_to_roman_numeral.f
rtl/b2r_pkg.sv
rtl/binary_to_roman_numeral.sv
dv/binary_to_roman_numeral_tb.sv
